// ===== rtl/core/lcdtf_pkg.sv =====
// Package for the LCD text nibble formatter: item types, character and command codes.
// It also holds the controller state type and the command and status structs.
// It depends on nothing else.
package lcdtf_pkg;

    localparam int MAX_DIGITS = 10;
    localparam int CNT_W = $clog2(MAX_DIGITS + 1);

    localparam logic [1:0] FUNC_BEGIN    = 2'd0;
    localparam logic [1:0] FUNC_FORMAT   = 2'd1;
    localparam logic [1:0] FUNC_VERBATIM = 2'd2;

    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_D       = 8'h64;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] SET_ADDR     = 8'h80;

    localparam logic [31:0] RECIP_10 = 32'hCCCC_CCCD;
    localparam int RECIP_SHIFT = 35;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  char_code;
        logic [6:0]  row_base;
        logic [6:0]  column;
        logic [31:0] number_value;
    } t_in_item;

    typedef struct packed {
        logic [3:0] nibble;
        logic       is_command;
        logic       last;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLR_HI,
        S_CLR_LO,
        S_ADR_HI,
        S_ADR_LO,
        S_CHR_HI,
        S_CHR_LO,
        S_DIV_MUL,
        S_DIV_SUB,
        S_DIG_HI,
        S_DIG_LO
    } t_state;

    typedef enum logic [1:0] {
        SRC_CLEAR,
        SRC_ADDR,
        SRC_CHAR,
        SRC_DIGIT
    } t_emit_src;

    typedef struct packed {
        logic      load_begin;
        logic      load_char;
        logic      set_pct;
        logic      clr_pct;
        logic      start_num;
        logic      div_mul;
        logic      div_sub;
        logic      emit;
        t_emit_src emit_src;
        logic      emit_lo;
        logic      emit_last;
        logic      dig_pop;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] in_func;
        logic       in_is_pct;
        logic       in_is_d;
        logic       pct;
        logic       out_free;
        logic       q_zero;
        logic       cnt_full;
        logic       cnt_one;
    } t_dp_sts;

endpackage

// ===== rtl/core/lcdtf_dp.sv =====
// Datapath of the LCD text nibble formatter: held number, percent flag, digit divider,
// digit stack and the output register.
// It depends on lcdtf_pkg.
module lcdtf_dp
    import lcdtf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_data,
    input  t_dp_cmd   i_cmd,
    input  logic      i_out_stall,
    output t_dp_sts   o_sts,
    output logic      o_out_valid,
    output t_out_item o_out_data
);

    logic [31:0] r_held;
    logic        r_pct;
    logic [7:0]  r_addr;
    logic [7:0]  r_char;
    logic [31:0] r_work;
    logic [63:0] r_prod;
    logic [3:0]  r_dig [MAX_DIGITS];
    logic [CNT_W-1:0] r_cnt;
    logic        r_out_valid;
    t_out_item   r_out;

    logic [28:0] quot;
    logic [31:0] quot_x10;
    logic [31:0] remain;
    logic [7:0]  emit_byte;
    logic [7:0]  n_addr;

    assign quot     = r_prod[63:RECIP_SHIFT];
    assign quot_x10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
    assign remain   = r_work - quot_x10;
    assign n_addr   = 8'({1'b0, i_in_data.row_base} + {1'b0, i_in_data.column}) + SET_ADDR;

    always_comb begin
        case (i_cmd.emit_src)
            SRC_CLEAR: emit_byte = CMD_CLEAR;
            SRC_ADDR:  emit_byte = r_addr;
            SRC_CHAR:  emit_byte = r_char;
            default:   emit_byte = CHAR_ZERO + {4'b0000, r_dig[0]};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_pct <= 1'b0;
            r_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load_begin) begin
                r_held <= i_in_data.number_value;
            end
            if (i_cmd.set_pct) begin
                r_pct <= 1'b1;
            end else if (i_cmd.clr_pct || i_cmd.load_begin) begin
                r_pct <= 1'b0;
            end
            if (i_cmd.start_num) begin
                r_cnt <= '0;
            end else if (i_cmd.div_sub) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (i_cmd.dig_pop) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_begin) begin
            r_addr <= n_addr;
        end
        if (i_cmd.load_char) begin
            r_char <= i_in_data.char_code;
        end
        if (i_cmd.start_num) begin
            r_work <= r_held;
        end else if (i_cmd.div_sub) begin
            r_work <= {3'b000, quot};
        end
        if (i_cmd.div_mul) begin
            r_prod <= 64'(r_work) * 64'(RECIP_10);
        end
        if (i_cmd.div_sub) begin
            for (int i = MAX_DIGITS - 1; i > 0; i--) begin
                r_dig[i] <= r_dig[i-1];
            end
            r_dig[0] <= remain[3:0];
        end else if (i_cmd.dig_pop) begin
            for (int i = 0; i < MAX_DIGITS - 1; i++) begin
                r_dig[i] <= r_dig[i+1];
            end
        end
        if (i_cmd.emit) begin
            r_out.nibble <= i_cmd.emit_lo ? emit_byte[3:0] : emit_byte[7:4];
            r_out.is_command <= (i_cmd.emit_src == SRC_CLEAR) || (i_cmd.emit_src == SRC_ADDR);
            r_out.last <= i_cmd.emit_last;
        end
    end

    assign o_sts.in_func   = i_in_data.func;
    assign o_sts.in_is_pct = (i_in_data.char_code == CHAR_PERCENT);
    assign o_sts.in_is_d   = (i_in_data.char_code == CHAR_D);
    assign o_sts.pct       = r_pct;
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;
    assign o_sts.q_zero    = (quot == '0);
    assign o_sts.cnt_full  = (r_cnt == CNT_W'(MAX_DIGITS - 1));
    assign o_sts.cnt_one   = (r_cnt == CNT_W'(1));

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/core/lcdtf_ctrl.sv =====
// Controller of the LCD text nibble formatter: decodes each item and sequences
// the nibble emission and the divide-by-ten steps of the datapath.
// It depends on lcdtf_pkg.
module lcdtf_ctrl
    import lcdtf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_dp_sts i_sts,
    output logic    o_in_stall,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_cmd.emit_src = SRC_CLEAR;
        o_in_stall = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_sts.in_func)
                        FUNC_BEGIN: begin
                            o_cmd.load_begin = 1'b1;
                            n_state = S_CLR_HI;
                        end
                        FUNC_FORMAT: begin
                            if (i_sts.in_is_pct) begin
                                o_cmd.set_pct = 1'b1;
                            end else if (i_sts.in_is_d && i_sts.pct) begin
                                o_cmd.clr_pct = 1'b1;
                                o_cmd.start_num = 1'b1;
                                n_state = S_DIV_MUL;
                            end else begin
                                o_cmd.clr_pct = 1'b1;
                                o_cmd.load_char = 1'b1;
                                n_state = S_CHR_HI;
                            end
                        end
                        FUNC_VERBATIM: begin
                            o_cmd.load_char = 1'b1;
                            n_state = S_CHR_HI;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_CLR_HI: begin
                o_cmd.emit_src = SRC_CLEAR;
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_CLR_LO;
                end
            end
            S_CLR_LO: begin
                o_cmd.emit_src = SRC_CLEAR;
                o_cmd.emit_lo = 1'b1;
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_ADR_HI;
                end
            end
            S_ADR_HI: begin
                o_cmd.emit_src = SRC_ADDR;
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_ADR_LO;
                end
            end
            S_ADR_LO: begin
                o_cmd.emit_src = SRC_ADDR;
                o_cmd.emit_lo = 1'b1;
                o_cmd.emit_last = 1'b1;
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_CHR_HI: begin
                o_cmd.emit_src = SRC_CHAR;
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_CHR_LO;
                end
            end
            S_CHR_LO: begin
                o_cmd.emit_src = SRC_CHAR;
                o_cmd.emit_lo = 1'b1;
                o_cmd.emit_last = 1'b1;
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_DIV_MUL: begin
                o_cmd.div_mul = 1'b1;
                n_state = S_DIV_SUB;
            end
            S_DIV_SUB: begin
                o_cmd.div_sub = 1'b1;
                if (i_sts.q_zero || i_sts.cnt_full) begin
                    n_state = S_DIG_HI;
                end else begin
                    n_state = S_DIV_MUL;
                end
            end
            S_DIG_HI: begin
                o_cmd.emit_src = SRC_DIGIT;
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_DIG_LO;
                end
            end
            S_DIG_LO: begin
                o_cmd.emit_src = SRC_DIGIT;
                o_cmd.emit_lo = 1'b1;
                o_cmd.emit_last = i_sts.cnt_one;
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.dig_pop = 1'b1;
                    n_state = i_sts.cnt_one ? S_IDLE : S_DIG_HI;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/lcd_text_nibble_formatter_unit.sv =====
// An item is taken only in the idle state; a begin or character item then emits its nibbles in turn,
// and a %d item first runs its division by ten, then emits its digits, most significant first.
// One item at a time: no new item is taken until the last nibble of the one before is emitted;
// a '%' item is taken without leaving the idle state, and output stalls hold the work up.
// Synchronous active-low reset clears the controller, the percent flag, the held number
// and the output valid; the sender must offer no item during reset, the block does not enforce it.
module lcd_text_nibble_formatter_unit
    import lcdtf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    lcdtf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    lcdtf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== rtl/core/lcdtf_checker.sv =====
// Port-level checker for the LCD text nibble formatter, bound to the top level.
// It depends on lcdtf_pkg.
module lcdtf_checker
    import lcdtf_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input t_in_item  i_in_data,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input t_out_item o_out_data,
    input logic      i_out_stall
);

    // A stalled item must hold.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("output item changed while stalled");

    // When new input is taken, any waiting item must close the previous message.
    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_in_stall |-> o_out_data.last)
        else $error("input taken while a message is unfinished");

    // Begin and verbatim items always produce output, so the input side closes.
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall &&
        (i_in_data.func == FUNC_BEGIN || i_in_data.func == FUNC_VERBATIM) |=> o_in_stall)
        else $error("no work started after an item that produces output");

    // A begin item sends four nibbles, so the input side stays closed while they are emitted.
    a_begin_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_data.func == FUNC_BEGIN |=> o_in_stall [*4])
        else $error("begin item finished too early");

endmodule

bind lcd_text_nibble_formatter_unit lcdtf_checker u_chk (.*);

// ===== bench/tb_lcd_text_nibble_formatter_unit.sv =====
// Self-checking testbench for lcd_text_nibble_formatter_unit: directed and random items,
// with a built-in predictor of the nibble stream and random stalls on both sides.
// It depends on lcdtf_pkg and the lcd_text_nibble_formatter_unit RTL.
`timescale 1ns / 100ps

module tb_lcd_text_nibble_formatter_unit;
    import lcdtf_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 60;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_REPORTS = 10;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    t_in_item  i_in_data;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;
    logic      i_out_stall;

    t_out_item   pending_nibbles[$];
    t_out_item   item_nibbles[$];
    t_out_item   expected_nibble;
    logic        model_percent;
    logic [31:0] model_number;

    int cycle_count;
    int mismatch_count;
    int items_sent;
    int nibbles_checked;
    int numbers_substituted;
    int sender_idle_pct;
    int receiver_idle_pct;
    int hold_left;
    bit hold_off_request;

    lcd_text_nibble_formatter_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("lcd_text_nibble_formatter_unit regression: fail");
        $finish;
    end

    // The receiver stalls at random, or for a long stretch when a hold-off is requested.
    initial begin
        i_out_stall = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99, 0) < receiver_idle_pct);
            end
        end
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("mismatch at cycle %0d: %s", cycle_count, what);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            nibbles_checked++;
            if (pending_nibbles.size() == 0) begin
                report_mismatch($sformatf("nibble %h cmd %b last %b arrived with none expected",
                    o_out_data.nibble, o_out_data.is_command, o_out_data.last));
            end else begin
                expected_nibble = pending_nibbles.pop_front();
                if (o_out_data.nibble !== expected_nibble.nibble) begin
                    report_mismatch($sformatf("nibble expected %h actual %h",
                        expected_nibble.nibble, o_out_data.nibble));
                end
                if (o_out_data.is_command !== expected_nibble.is_command) begin
                    report_mismatch($sformatf("is_command expected %b actual %b",
                        expected_nibble.is_command, o_out_data.is_command));
                end
                if (o_out_data.last !== expected_nibble.last) begin
                    report_mismatch($sformatf("last expected %b actual %b",
                        expected_nibble.last, o_out_data.last));
                end
            end
        end
    end

    task automatic add_byte_nibbles(input logic [7:0] code, input logic is_cmd);
        t_out_item part;
        part.nibble = code[7:4];
        part.is_command = is_cmd;
        part.last = 1'b0;
        item_nibbles.push_back(part);
        part.nibble = code[3:0];
        item_nibbles.push_back(part);
    endtask

    task automatic add_number_digits(input logic [31:0] value);
        logic [7:0]  digit_chars[$];
        logic [31:0] rest;
        rest = value;
        if (rest < 10) begin
            add_byte_nibbles(CHAR_ZERO + rest[7:0], 1'b0);
        end else begin
            while (rest != 0 && digit_chars.size() < MAX_DIGITS) begin
                digit_chars.push_front(CHAR_ZERO + 8'(rest % 10));
                rest = rest / 10;
            end
            foreach (digit_chars[k]) begin
                add_byte_nibbles(digit_chars[k], 1'b0);
            end
        end
    endtask

    task automatic predict_item_nibbles(input t_in_item item);
        t_out_item  tail;
        logic [7:0] address;
        item_nibbles.delete();
        case (item.func)
            FUNC_BEGIN: begin
                model_number = item.number_value;
                model_percent = 1'b0;
                address = 8'(item.row_base) + 8'(item.column) + SET_ADDR;
                add_byte_nibbles(CMD_CLEAR, 1'b1);
                add_byte_nibbles(address, 1'b1);
            end
            FUNC_FORMAT: begin
                if (item.char_code == CHAR_PERCENT) begin
                    model_percent = 1'b1;
                end else if (item.char_code == CHAR_D && model_percent) begin
                    model_percent = 1'b0;
                    numbers_substituted++;
                    add_number_digits(model_number);
                end else begin
                    model_percent = 1'b0;
                    add_byte_nibbles(item.char_code, 1'b0);
                end
            end
            FUNC_VERBATIM: begin
                add_byte_nibbles(item.char_code, 1'b0);
            end
            default: begin
            end
        endcase
        if (item_nibbles.size() > 0) begin
            tail = item_nibbles[item_nibbles.size() - 1];
            tail.last = 1'b1;
            item_nibbles[item_nibbles.size() - 1] = tail;
        end
        foreach (item_nibbles[k]) begin
            pending_nibbles.push_back(item_nibbles[k]);
        end
    endtask

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_item(input t_in_item item);
        while ($urandom_range(99, 0) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= item;
        do @(posedge i_clk); while (o_in_stall);
        predict_item_nibbles(item);
        if (item.func != FUNC_UNUSED) begin
            items_sent++;
        end
        @(negedge i_clk);
    endtask

    function automatic t_in_item make_item(input logic [1:0] func, input logic [7:0] code);
        t_in_item item;
        item.func = func;
        item.char_code = code;
        item.row_base = 7'($urandom_range(127, 0));
        item.column = 7'($urandom_range(127, 0));
        item.number_value = $urandom;
        return item;
    endfunction

    task automatic send_begin(input logic [6:0] row, input logic [6:0] col,
                              input logic [31:0] value);
        t_in_item item;
        item = make_item(FUNC_BEGIN, 8'($urandom_range(255, 0)));
        item.row_base = row;
        item.column = col;
        item.number_value = value;
        send_item(item);
    endtask

    task automatic send_percent_d();
        send_item(make_item(FUNC_FORMAT, CHAR_PERCENT));
        send_item(make_item(FUNC_FORMAT, CHAR_D));
    endtask

    function automatic logic [31:0] random_number();
        case ($urandom_range(3, 0))
            0: return 32'($urandom_range(9, 0));
            1: return $urandom;
            default: return $urandom >> $urandom_range(31, 1);
        endcase
    endfunction

    function automatic logic [7:0] random_text_char();
        int pick;
        pick = $urandom_range(99, 0);
        if (pick < 25) begin
            return CHAR_PERCENT;
        end else if (pick < 45) begin
            return CHAR_D;
        end
        return 8'($urandom_range(255, 0));
    endfunction

    task automatic test_begin_commands();
        send_begin(7'h7f, 7'h7f, 32'h0000_0000);
        send_begin(7'h00, 7'h00, 32'hffff_ffff);
    endtask

    task automatic test_number_substitution();
        send_begin(7'($urandom_range(127, 0)), 7'($urandom_range(127, 0)), 32'hffff_ffff);
        send_percent_d();
        send_begin(7'h40, 7'h05, 32'd0);
        send_percent_d();
        send_begin(7'h14, 7'h7f, 32'd9);
        send_percent_d();
        send_begin(7'h54, 7'h00, 32'd10);
        send_percent_d();
    endtask

    task automatic test_percent_handling();
        send_item(make_item(FUNC_FORMAT, CHAR_PERCENT));
        send_percent_d();
        send_item(make_item(FUNC_FORMAT, CHAR_PERCENT));
        send_item(make_item(FUNC_FORMAT, 8'h00));
        send_item(make_item(FUNC_FORMAT, 8'hff));
    endtask

    task automatic test_verbatim_and_unused();
        send_item(make_item(FUNC_FORMAT, CHAR_PERCENT));
        send_item(make_item(FUNC_VERBATIM, 8'h41));
        send_item(make_item(FUNC_UNUSED, CHAR_D));
        send_item(make_item(FUNC_FORMAT, CHAR_D));
        send_item(make_item(FUNC_VERBATIM, 8'h00));
        send_item(make_item(FUNC_VERBATIM, 8'hff));
        send_item(make_item(FUNC_VERBATIM, CHAR_PERCENT));
    endtask

    // Mostly whole messages with random text, plus stray items of any kind.
    task automatic test_random_text(input int count);
        int start_count;
        int text_len;
        start_count = items_sent;
        while (items_sent - start_count < count) begin
            if ($urandom_range(99, 0) < 80) begin
                send_begin(7'($urandom_range(127, 0)), 7'($urandom_range(127, 0)),
                           random_number());
                text_len = $urandom_range(8, 1);
                repeat (text_len) begin
                    case ($urandom_range(9, 0))
                        0, 1: send_item(make_item(FUNC_VERBATIM, random_text_char()));
                        2, 3: send_percent_d();
                        default: send_item(make_item(FUNC_FORMAT, random_text_char()));
                    endcase
                end
            end else begin
                send_item(make_item(2'($urandom_range(3, 0)), random_text_char()));
            end
        end
    endtask

    task automatic test_output_backpressure();
        hold_off_request = 1'b1;
        send_begin(7'h00, 7'h40, 32'hffff_ffff);
        repeat (3) begin
            send_percent_d();
            send_item(make_item(FUNC_FORMAT, random_text_char()));
            send_item(make_item(FUNC_VERBATIM, random_text_char()));
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        hold_off_request = 1'b0;
        model_percent = 1'b0;
        model_number = '0;
        mismatch_count = 0;
        items_sent = 0;
        nibbles_checked = 0;
        numbers_substituted = 0;
        sender_idle_pct = 29;
        receiver_idle_pct = 61;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_begin_commands();
        test_number_substitution();
        test_percent_handling();
        test_verbatim_and_unused();
        test_random_text(35);

        sender_idle_pct = 61;
        receiver_idle_pct = 29;
        test_random_text(35);

        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        test_output_backpressure();
        test_random_text(35);
        i_in_valid <= 1'b0;

        while (pending_nibbles.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (pending_nibbles.size() != 0) begin
            report_mismatch($sformatf("%0d expected nibbles never arrived",
                pending_nibbles.size()));
        end
        $display("Covered %0d items with %0d number substitutions and %0d nibbles checked,",
            items_sent, numbers_substituted, nibbles_checked);
        $display("under idling on each side, none, and a %0d-cycle output hold; %0d mismatches.",
            HOLD_CYCLES, mismatch_count);
        if (mismatch_count == 0) begin
            $display("lcd_text_nibble_formatter_unit regression: pass");
        end else begin
            $display("lcd_text_nibble_formatter_unit regression: fail");
        end
        $finish;
    end

endmodule
